// ===== rtl/lhr_pkg.sv =====
// Shared types, widths and constants of the latency histogram recorder.
package lhr_pkg;

  // Sizing of the histogram and of the datapath
  localparam int MAX_BUCKETS = 1024;
  localparam int BUCKET_AW   = $clog2(MAX_BUCKETS);
  localparam int COUNT_W     = 32;
  localparam int LAT_W       = 48;
  localparam int SUM_W       = 64;
  localparam int IDX_W       = 10;
  localparam int TICKS_W     = 16;
  localparam int THR_W       = 24;
  localparam int BIAS_W      = 24;
  localparam int NBUCK_W     = 11;

  // APB register port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Divider: quotient bits retired per cycle
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_STEPS     = LAT_W / DIV_STEP_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [LAT_W-1:0]   LAT_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [TICKS_W-1:0] TICKS_RST = TICKS_W'(1000);
  localparam logic [NBUCK_W-1:0] NBUCK_RST = NBUCK_W'(32);

  // Register map, word index
  typedef enum logic [1:0] {
    REG_TICKS    = 2'd0,
    REG_STOP_THR = 2'd1,
    REG_BIAS     = 2'd2,
    REG_NBUCK    = 2'd3
  } cfg_reg_t;

  // Operation codes of an input transaction
  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  // Top level sequencer
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDDATA,
    S_DIV,
    S_CALC,
    S_BIN,
    S_ADD,
    S_EMIT
  } lhr_state_t;

endpackage

// ===== rtl/lhr_ram.sv =====
// Generic simple dual port RAM with registered read data.
module lhr_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lhr_div.sv =====
// Iterative restoring divider: sample cycles divided by ticks per microsecond.
module lhr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lhr_pkg::LAT_W-1:0]   dividend,
  input  logic [lhr_pkg::TICKS_W-1:0] divisor,
  output logic                        done,
  output logic [lhr_pkg::LAT_W-1:0]   quotient
);

  import lhr_pkg::*;

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [LAT_W-1:0]     quo_r;
  logic [TICKS_W-1:0]   rem_r;
  logic [TICKS_W-1:0]   div_r;

  logic [LAT_W-1:0]     quo_nxt;
  logic [TICKS_W-1:0]   rem_nxt;
  logic [TICKS_W:0]     trial;

  // Several shift-compare-subtract steps per cycle
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    trial   = '0;
    for (int k = 0; k < DIV_STEP_BITS; k++) begin
      trial   = {rem_nxt, quo_nxt[LAT_W-1]};
      quo_nxt = {quo_nxt[LAT_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt    = TICKS_W'(trial - {1'b0, div_r});
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[TICKS_W-1:0];
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/latency_histogram_recorder.sv =====
// Latency histogram recorder: top level with sequencer, statistics and register port.
//
//  channel  | direction | handshake                  | transaction
//  ---------+-----------+----------------------------+-------------------------------------
//  in_      | input     | in_valid / in_stall        | op, latency_cycles, read_index
//  out_     | output    | out_valid / out_stall      | bucket count, index, min, max, sum, flags
//  APB      | input     | psel, penable, pwrite      | ticks, stop threshold, bias, buckets
//
//  A record waits on the divider (12 steps of 4 quotient bits, then a hand-over), then
//  threshold check, bucket read, update and emit. A read passes a data step to emit, an
//  ignored sample goes straight to emit, one reaching the stop threshold skips the bucket.
//  After reset the histogram RAM is cleared one entry a cycle, all MAX_BUCKETS = 1024 entries;
//  no input is accepted meanwhile, register writes are.
//  One transaction is in work at a time; a result held by out_stall lets the next be taken, which then waits in emit.
module latency_histogram_recorder (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [lhr_pkg::LAT_W-1:0]   in_latency_cycles,
  input  logic [lhr_pkg::IDX_W-1:0]   in_read_index,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lhr_pkg::COUNT_W-1:0] out_bucket_count,
  output logic [lhr_pkg::IDX_W-1:0]   out_bucket_used,
  output logic [lhr_pkg::LAT_W-1:0]   out_min_us,
  output logic [lhr_pkg::LAT_W-1:0]   out_max_us,
  output logic [lhr_pkg::SUM_W-1:0]   out_overflow_us_sum,
  output logic                        out_stopped,
  output logic                        out_saturated,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lhr_pkg::PADDR_W-1:0] paddr,
  input  logic [lhr_pkg::PDATA_W-1:0] pwdata,
  output logic [lhr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  import lhr_pkg::*;

  lhr_state_t state_r, state_nxt;

  // Configuration
  logic [TICKS_W-1:0] cfg_ticks_r;
  logic [THR_W-1:0]   cfg_thr_r;
  logic [BIAS_W-1:0]  cfg_bias_r;
  logic [NBUCK_W-1:0] cfg_nbuck_r;
  cfg_reg_t           reg_sel;

  // Statistics
  logic [LAT_W-1:0] min_r;
  logic [LAT_W-1:0] max_r;
  logic [SUM_W-1:0] ovf_r;
  logic             stop_r;
  logic             sat_r;

  // Work registers
  logic [BUCKET_AW-1:0] clr_addr_r;
  logic [LAT_W-1:0]     idx_r;
  logic [LAT_W-1:0]     extra_r;
  logic                 ovf_hit_r;
  logic [BUCKET_AW-1:0] bucket_r;
  logic                 rd_ok_r;
  logic [COUNT_W-1:0]   res_count_r;
  logic [IDX_W-1:0]     res_idx_r;

  // Output register
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic [LAT_W-1:0]   out_min_r;
  logic [LAT_W-1:0]   out_max_r;
  logic [SUM_W-1:0]   out_sum_r;
  logic               out_stop_r;
  logic               out_sat_r;
  logic               out_load;

  // RAM and divider connections
  logic                 ram_we;
  logic [BUCKET_AW-1:0] ram_waddr;
  logic [COUNT_W-1:0]   ram_wdata;
  logic                 ram_re;
  logic [BUCKET_AW-1:0] ram_raddr;
  logic [COUNT_W-1:0]   ram_rdata;
  logic                 div_start;
  logic                 div_done;
  logic [LAT_W-1:0]     div_quo;
  logic [TICKS_W-1:0]   div_divisor;

  // Datapath terms
  logic [LAT_W-1:0]     us_w;
  logic                 hit_thr;
  logic [LAT_W-1:0]     idx_b;
  logic [LAT_W-1:0]     nb_w;
  logic                 over_w;
  logic [BUCKET_AW-1:0] bucket_w;
  logic [LAT_W-1:0]     extra_w;
  logic [SUM_W:0]       sum_w;
  logic                 cnt_full;
  logic [COUNT_W-1:0]   cnt_nxt;
  logic                 rd_ok_w;

  lhr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_latency_cycles),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  lhr_ram #(
    .DEPTH (MAX_BUCKETS),
    .WIDTH (COUNT_W)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A divisor of zero counts as one
  assign div_divisor = (cfg_ticks_r == '0) ? TICKS_W'(1) : cfg_ticks_r;

  // Microseconds, threshold and bias
  assign us_w    = (div_quo == LAT_MAX) ? LAT_MAX : div_quo + LAT_W'(1);
  assign hit_thr = (cfg_thr_r != '0) && (us_w >= LAT_W'(cfg_thr_r));
  assign idx_b   = (div_quo > LAT_W'(cfg_bias_r)) ? div_quo - LAT_W'(cfg_bias_r) : '0;

  // Buckets in use, clamped to 1..MAX_BUCKETS, and the overflow clamp
  always_comb begin
    nb_w = LAT_W'(cfg_nbuck_r);
    if (nb_w == '0) begin
      nb_w = LAT_W'(1);
    end else if (nb_w > LAT_W'(MAX_BUCKETS)) begin
      nb_w = LAT_W'(MAX_BUCKETS);
    end
  end
  assign over_w   = (idx_r >= nb_w);
  assign extra_w  = idx_r - nb_w;
  assign bucket_w = over_w ? BUCKET_AW'(nb_w - LAT_W'(1)) : BUCKET_AW'(idx_r);

  // Overflow sum and counter update, both saturating
  assign sum_w    = {1'b0, ovf_r} + (SUM_W + 1)'(extra_r);
  assign cnt_full = (ram_rdata == COUNT_MAX);
  assign cnt_nxt  = cnt_full ? ram_rdata : ram_rdata + COUNT_W'(1);

  assign rd_ok_w = (32'(in_read_index) < MAX_BUCKETS);

  // Sequencer: next state and control
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = BUCKET_AW'(in_read_index);
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr_r == BUCKET_AW'(MAX_BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (op_t'(in_op) == OP_READ) begin
            ram_re    = 1'b1;
            state_nxt = S_RDDATA;
          end else if (stop_r) begin
            state_nxt = S_EMIT;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_RDDATA: state_nxt = S_EMIT;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: state_nxt = hit_thr ? S_EMIT : S_BIN;
      S_BIN: begin
        ram_re    = 1'b1;
        ram_raddr = bucket_w;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        ram_we    = 1'b1;
        ram_waddr = bucket_r;
        ram_wdata = cnt_nxt;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + BUCKET_AW'(1);
      end
    end
  end

  // Register writes
  assign reg_sel = cfg_reg_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ticks_r <= TICKS_RST;
      cfg_thr_r   <= '0;
      cfg_bias_r  <= '0;
      cfg_nbuck_r <= NBUCK_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_TICKS:    cfg_ticks_r <= pwdata[TICKS_W-1:0];
        REG_STOP_THR: cfg_thr_r   <= pwdata[THR_W-1:0];
        REG_BIAS:     cfg_bias_r  <= pwdata[BIAS_W-1:0];
        REG_NBUCK:    cfg_nbuck_r <= pwdata[NBUCK_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_sel)
      REG_TICKS:    prdata = PDATA_W'(cfg_ticks_r);
      REG_STOP_THR: prdata = PDATA_W'(cfg_thr_r);
      REG_BIAS:     prdata = PDATA_W'(cfg_bias_r);
      REG_NBUCK:    prdata = PDATA_W'(cfg_nbuck_r);
      default:      prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // Statistics and sticky flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= LAT_MAX;
      max_r  <= '0;
      ovf_r  <= '0;
      stop_r <= 1'b0;
      sat_r  <= 1'b0;
    end else begin
      case (state_r)
        S_CALC: begin
          if (hit_thr) begin
            stop_r <= 1'b1;
          end else begin
            if (us_w > max_r) begin
              max_r <= us_w;
            end
            if (us_w < min_r) begin
              min_r <= us_w;
            end
          end
        end
        S_ADD: begin
          if (ovf_hit_r) begin
            ovf_r <= sum_w[SUM_W] ? '1 : sum_w[SUM_W-1:0];
          end
          // full counter or carry out of the overflow sum
          if (cnt_full || (ovf_hit_r && sum_w[SUM_W])) begin
            sat_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Work registers and the result of the transaction in hand
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        rd_ok_r     <= rd_ok_w;
        res_idx_r   <= (op_t'(in_op) == OP_READ) ? in_read_index : '0;
        res_count_r <= '0;
      end
      S_RDDATA: res_count_r <= rd_ok_r ? ram_rdata : '0;
      S_CALC: begin
        idx_r <= idx_b;
        if (hit_thr) begin
          res_count_r <= '0;
          res_idx_r   <= '0;
        end
      end
      S_BIN: begin
        bucket_r  <= bucket_w;
        extra_r   <= extra_w;
        ovf_hit_r <= over_w;
      end
      S_ADD: begin
        res_count_r <= cnt_nxt;
        res_idx_r   <= IDX_W'(bucket_r);
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count_r <= res_count_r;
      out_idx_r   <= res_idx_r;
      out_min_r   <= min_r;
      out_max_r   <= max_r;
      out_sum_r   <= ovf_r;
      out_stop_r  <= stop_r;
      out_sat_r   <= sat_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_bucket_count    = out_count_r;
  assign out_bucket_used     = out_idx_r;
  assign out_min_us          = out_min_r;
  assign out_max_us          = out_max_r;
  assign out_overflow_us_sum = out_sum_r;
  assign out_stopped         = out_stop_r;
  assign out_saturated       = out_sat_r;

  // Checks
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n) stop_r |=> stop_r)
    else $error("stop flag cleared");

  a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n) sat_r |=> sat_r)
    else $error("saturation flag cleared");

  a_ram_port_clash: assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
    else $error("histogram read and write in the same cycle");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result presented outside the emit step");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished while the sequencer was not waiting");

endmodule
